// ----- rtl/core/ipd_pkg.sv -----
package ipd_pkg;

    // Default width of the payload length and byte counter
    localparam int unsigned LENGTH_BITS_DEF = 16;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 16;

    // Header text "+IPD," in arrival order
    localparam logic [BYTE_W-1:0] HDR_0 = 8'h2B;
    localparam logic [BYTE_W-1:0] HDR_1 = 8'h49;
    localparam logic [BYTE_W-1:0] HDR_2 = 8'h50;
    localparam logic [BYTE_W-1:0] HDR_3 = 8'h44;
    localparam logic [BYTE_W-1:0] HDR_4 = 8'h2C;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    typedef enum logic [2:0] {
        MODE_HUNT    = 3'b001,
        MODE_LENGTH  = 3'b010,
        MODE_PAYLOAD = 3'b100
    } mode_t;

endpackage

// ----- rtl/core/ipd_in_stage.sv -----
module ipd_in_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ipd_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                      word_valid,
    input  logic                      word_take,
    output logic [ipd_pkg::BYTE_W-1:0] word_byte
);
    import ipd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // Refill in the same cycle the held word is consumed
    assign s_ready = !valid_reg || word_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (word_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign word_valid = valid_reg;
    assign word_byte  = byte_reg;

endmodule

// ----- rtl/core/ipd_parser.sv -----
module ipd_parser #(
    parameter int unsigned LENGTH_BITS = ipd_pkg::LENGTH_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        word_valid,
    output logic                        word_take,
    input  logic [ipd_pkg::BYTE_W-1:0]  word_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ipd_pkg::BYTE_W-1:0]  m_payload_byte,
    output logic [ipd_pkg::INDEX_W-1:0] m_byte_index,
    output logic                        m_last_byte
);
    import ipd_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [BYTE_W-1:0]      win_reg [4];
    logic [BYTE_W-1:0]      win_next [4];
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [LENGTH_BITS+INDEX_W-1:0] cnt_wide;
    logic [LENGTH_BITS-1:0] digit_ext;
    logic                   is_digit;
    logic                   hdr_hit;
    logic                   emit;
    logic                   proc;
    logic                   last;

    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic                   out_last_reg;

    assign is_digit  = (word_byte >= ASCII_ZERO) && (word_byte <= ASCII_NINE);
    assign digit_ext = LENGTH_BITS'(word_byte - ASCII_ZERO);
    assign hdr_hit   = (win_reg[0] == HDR_0) && (win_reg[1] == HDR_1) &&
                       (win_reg[2] == HDR_2) && (win_reg[3] == HDR_3) &&
                       (word_byte == HDR_4);
    assign cnt_inc   = cnt_reg + LENGTH_BITS'(1);
    assign last      = (cnt_inc == len_reg);
    assign cnt_wide  = {{INDEX_W{1'b0}}, cnt_reg};
    assign emit      = (mode_reg == MODE_PAYLOAD) && (cnt_reg < len_reg);

    // Words that produce no result never wait on the output side
    assign proc      = word_valid && (!emit || !out_valid_reg || m_ready);
    assign word_take = proc;

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        for (int i = 0; i < 4; i++) begin
            win_next[i] = win_reg[i];
        end
        if (proc) begin
            case (mode_reg)
                MODE_LENGTH: begin
                    if (is_digit) begin
                        len_next = (len_reg << 3) + (len_reg << 1) + digit_ext;
                    end else if (len_reg == '0) begin
                        mode_next = MODE_HUNT;
                    end else begin
                        mode_next = MODE_PAYLOAD;
                    end
                end
                MODE_PAYLOAD: begin
                    if (emit) begin
                        cnt_next = cnt_inc;
                        if (last) begin
                            mode_next = MODE_HUNT;
                        end
                    end else begin
                        // Count exhausted: drop to hunt and hunt this word
                        mode_next   = MODE_HUNT;
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        win_next[2] = win_reg[3];
                        win_next[3] = word_byte;
                        if (hdr_hit) begin
                            mode_next = MODE_LENGTH;
                            len_next  = '0;
                            cnt_next  = '0;
                        end
                    end
                end
                default: begin
                    mode_next   = MODE_HUNT;
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = word_byte;
                    if (hdr_hit) begin
                        mode_next = MODE_LENGTH;
                        len_next  = '0;
                        cnt_next  = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_HUNT;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            out_byte_reg  <= word_byte;
            out_index_reg <= cnt_wide[INDEX_W-1:0];
            out_last_reg  <= last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_payload_byte = out_byte_reg;
    assign m_byte_index   = out_index_reg;
    assign m_last_byte    = out_last_reg;

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_PAYLOAD) |-> (len_reg != '0))
        else $error("payload mode entered with zero length");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_PAYLOAD) |-> (cnt_reg < len_reg))
        else $error("byte count reached length while still in payload mode");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(proc && emit))
        else $error("pending result overwritten");

    a_hunt_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && emit && last) |=> (mode_reg == MODE_HUNT))
        else $error("mode not back to hunt after last byte");

endmodule

// ----- rtl/core/ipd_payload_deframer_core.sv -----
// Channel   Direction  Ports                                         Handshake
// s_        in         s_rx_byte                                     s_valid/s_ready
// m_        out        m_payload_byte, m_byte_index, m_last_byte     m_valid/m_ready
//
// One word per cycle sustained unless a payload word waits on a held result; an accepted
// word goes through the input register, then parse logic, into the result register.
// Synchronous active-low reset clears mode, header window, length, count and both valid flags.
// Header, length and terminator words never stall on m_ready; only payload
// words wait while a result is held, and the input register absorbs one word.
module ipd_payload_deframer_core #(
    parameter int unsigned LENGTH_BITS = ipd_pkg::LENGTH_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ipd_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ipd_pkg::BYTE_W-1:0]  m_payload_byte,
    output logic [ipd_pkg::INDEX_W-1:0] m_byte_index,
    output logic                        m_last_byte
);
    import ipd_pkg::*;

    logic              word_valid;
    logic              word_take;
    logic [BYTE_W-1:0] word_byte;

    ipd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .word_valid (word_valid),
        .word_take  (word_take),
        .word_byte  (word_byte)
    );

    ipd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .word_valid     (word_valid),
        .word_take      (word_take),
        .word_byte      (word_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_byte_index   (m_byte_index),
        .m_last_byte    (m_last_byte)
    );

endmodule

// ----- tb/tb_ipd_payload_deframer_core.sv -----
`timescale 1ns / 100ps

module tb_ipd_payload_deframer_core;
    import ipd_pkg::*;

    localparam logic [BYTE_W-1:0] COLON = 8'h3A;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               last;
    } payload_word_t;

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_rx_byte      = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [BYTE_W-1:0]   m_payload_byte;
    logic [INDEX_W-1:0]  m_byte_index;
    logic                m_last_byte;

    // expected payload words, oldest first
    payload_word_t       expected_words[$];
    payload_word_t       want;
    int unsigned         error_count    = 0;
    int unsigned         words_sent     = 0;
    bit                  idle_on        = 1'b0;

    // deframer state mirror
    logic [BYTE_W-1:0]          hunt_window[4];
    mode_t                      parse_mode;
    logic [LENGTH_BITS_DEF-1:0] frame_len;
    logic [LENGTH_BITS_DEF-1:0] bytes_out;

    ipd_payload_deframer_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_byte_index   (m_byte_index),
        .m_last_byte    (m_last_byte)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    initial begin
        #2_000_000;
        $display("tb_ipd_payload_deframer_core failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("%0t ns mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic clear_deframer();
        foreach (hunt_window[i]) begin
            hunt_window[i] = '0;
        end
        parse_mode = MODE_HUNT;
        frame_len  = '0;
        bytes_out  = '0;
    endtask

    // Advance the mirror by one accepted word; queue the payload word it yields.
    task automatic deframe_word(input logic [BYTE_W-1:0] b);
        payload_word_t              w;
        logic                       hit;
        logic [LENGTH_BITS_DEF-1:0] next_cnt;
        if (parse_mode == MODE_LENGTH) begin
            if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                frame_len = LENGTH_BITS_DEF'(frame_len * 10 + (b - ASCII_ZERO));
            end else begin
                parse_mode = (frame_len == 0) ? MODE_HUNT : MODE_PAYLOAD;
            end
            return;
        end
        if (parse_mode == MODE_PAYLOAD) begin
            if (bytes_out < frame_len) begin
                next_cnt = bytes_out + 1'b1;
                w.data   = b;
                w.index  = bytes_out[INDEX_W-1:0];
                w.last   = (next_cnt == frame_len);
                expected_words.push_back(w);
                bytes_out = next_cnt;
                if (w.last) begin
                    parse_mode = MODE_HUNT;
                end
                return;
            end
            parse_mode = MODE_HUNT;
        end
        hit = (hunt_window[0] == HDR_0) && (hunt_window[1] == HDR_1) &&
              (hunt_window[2] == HDR_2) && (hunt_window[3] == HDR_3) && (b == HDR_4);
        hunt_window[0] = hunt_window[1];
        hunt_window[1] = hunt_window[2];
        hunt_window[2] = hunt_window[3];
        hunt_window[3] = b;
        if (hit) begin
            parse_mode = MODE_LENGTH;
            frame_len  = '0;
            bytes_out  = '0;
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_word(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_word(b);
        words_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_word(t[i]);
        end
    endtask

    task automatic send_header();
        logic [BYTE_W-1:0] hdr[5] = '{HDR_0, HDR_1, HDR_2, HDR_3, HDR_4};
        foreach (hdr[i]) begin
            send_word(hdr[i]);
        end
    endtask

    task automatic send_frame(input string digits, input logic [BYTE_W-1:0] term,
                              input int unsigned n_data);
        send_header();
        send_text(digits);
        send_word(term);
        repeat (n_data) send_word(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stall bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h index %0d last %b",
                                          m_payload_byte, m_byte_index, m_last_byte));
            end else begin
                want = expected_words.pop_front();
                if (m_payload_byte !== want.data) begin
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              m_payload_byte, want.data));
                end
                if (m_byte_index !== want.index) begin
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              m_byte_index, want.index));
                end
                if (m_last_byte !== want.last) begin
                    report_mismatch($sformatf("last_byte %b, want %b at index %0d",
                                              m_last_byte, want.last, want.index));
                end
            end
        end
    end

    // Overlapping starts, near misses and extreme data bytes.
    task automatic test_header_match();
        send_text("x+IP");
        send_frame("3", COLON, 1);
        send_word(8'h00);
        send_word(8'hFF);
        send_text("+IPD;");
        send_word(HDR_0);
        send_frame("1", COLON, 1);
    endtask

    task automatic test_length_edges();
        // zero length: straight back to hunt
        send_frame("0", COLON, 0);
        // empty digit field is a zero length too
        send_header();
        send_word(COLON);
        send_word(HDR_0);
        // wraps to a length of one
        send_frame("65537", COLON, 1);
        // leading zeros and a terminator other than a colon
        send_frame("003", "x", 3);
    endtask

    // Header text inside a payload is data; a header right after the last word is hunted.
    task automatic test_payload_boundaries();
        send_frame("5", COLON, 0);
        send_header();
        send_frame("1", COLON, 1);
        send_frame("2", COLON, 2);
        send_text("9:");
    endtask

    task automatic send_random_burst();
        logic [BYTE_W-1:0] hdr[5] = '{HDR_0, HDR_1, HDR_2, HDR_3, HDR_4};
        logic [BYTE_W-1:0] term;
        int unsigned       len;
        int unsigned       kind;
        string             digits;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) send_word(BYTE_W'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            // broken header
            for (int i = 0; i < $urandom_range(1, 4); i++) begin
                send_word(hdr[i]);
            end
            send_word(BYTE_W'($urandom_range(0, 255)));
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
            case ($urandom_range(0, 7))
                0: digits = $sformatf("0%0d", len);
                1: digits = $sformatf("%0d", len + 65536);
                default: digits = $sformatf("%0d", len);
            endcase
            term = COLON;
            if ($urandom_range(0, 7) == 0) begin
                do term = BYTE_W'($urandom_range(0, 255));
                while (term >= ASCII_ZERO && term <= ASCII_NINE);
            end
            send_header();
            send_text(digits);
            send_word(term);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_word(hdr[$urandom_range(0, 4)]);
                end else begin
                    send_word(BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic test_random_traffic(input int unsigned stop_at);
        while (words_sent < stop_at) begin
            idle_on = ($urandom_range(0, 5) != 0);
            send_random_burst();
        end
    endtask

    // Hold the sender until every pending payload word has come out.
    task automatic test_drained_pause();
        idle_on = 1'b1;
        send_frame("4", COLON, 3);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        send_word(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_back_to_back(input int unsigned stop_at);
        idle_on = 1'b0;
        while (words_sent < stop_at) begin
            send_random_burst();
        end
    endtask

    initial begin
        clear_deframer();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_on = 1'b1;
        test_header_match();
        test_length_edges();
        test_payload_boundaries();
        test_random_traffic(300);
        test_drained_pause();
        test_random_traffic(480);
        test_back_to_back(600);

        s_valid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_ipd_payload_deframer_core passed");
        end else begin
            $display("tb_ipd_payload_deframer_core failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ipd_pkg.sv
rtl/core/ipd_in_stage.sv
rtl/core/ipd_parser.sv
rtl/core/ipd_payload_deframer_core.sv
tb/tb_ipd_payload_deframer_core.sv
